@@ hdl/assert_macros.svh @@
// assertion helpers included by the receiver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, quiet while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_RST(label, prop, msg)

`endif

`endif

@@ hdl/efr_pkg.sv @@
package efr_pkg;

    // frame geometry
    localparam int PAYLOAD_BYTES = 3;
    localparam int TYPE_COUNT    = 9;

    localparam int ID_W      = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam int REM_W     = $clog2(PAYLOAD_BYTES + 2);
    localparam int FRAME_ID_W = 4;

    // type bytes, index is the frame id
    localparam logic [7:0] TYPE_TABLE [16] = '{
        8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
        8'h62, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71
    };

    // configuration register reset values
    localparam logic [7:0] RST_ESCAPE     = 8'd16;
    localparam logic [7:0] RST_BEGIN      = 8'd2;
    localparam logic [7:0] RST_END        = 8'd3;
    localparam logic [7:0] RST_ERROR      = 8'd4;
    localparam logic [8:0] RST_POLY       = 9'd263;
    localparam logic [7:0] RST_DESCRIPTOR = 8'd255;
    localparam logic [7:0] RST_TIMESTAMP  = 8'd254;

    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_ESCAPE     = 3'd0,
        REG_BEGIN      = 3'd1,
        REG_END        = 3'd2,
        REG_ERROR      = 3'd3,
        REG_POLY       = 3'd4,
        REG_DESCRIPTOR = 3'd5,
        REG_TIMESTAMP  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TYPE,
        PH_FRAME
    } t_phase;

    typedef enum logic [2:0] {
        ERR_BEGIN_BUSY   = 3'd0,
        ERR_SHORT        = 3'd1,
        ERR_CRC          = 3'd2,
        ERR_REMOTE       = 3'd3,
        ERR_MIDFRAME     = 3'd4,
        ERR_BAD_ESCAPE   = 3'd5,
        ERR_TOO_LONG     = 3'd6,
        ERR_UNKNOWN_TYPE = 3'd7
    } t_err_kind;

    typedef struct packed {
        logic                  hit;
        logic [ID_W-1:0]       id;
    } t_type_hit;

    typedef struct packed {
        logic                  is_error;
        logic [FRAME_ID_W-1:0] frame_id;
        logic [7:0]            payload_first;
        logic [7:0]            payload_second;
        logic [7:0]            payload_third;
        logic                  is_timestamp;
        t_err_kind             error_kind;
        logic [7:0]            bad_type_byte;
    } t_result;

    // lowest matching id wins
    function automatic t_type_hit type_lookup(input logic [7:0] b);
        t_type_hit h;
        h = '0;
        for (int i = TYPE_COUNT - 1; i >= 0; i--) begin
            if (TYPE_TABLE[i] == b) begin
                h.hit = 1'b1;
                h.id  = ID_W'(i);
            end
        end
        return h;
    endfunction

endpackage

@@ hdl/escaped_frame_receiver_crc8_unit.sv @@
// Byte-stuffed frame receiver with CRC-8 check. One received byte is taken per
// transfer on the input channel, and at most one record (data or error) leaves
// per input byte on the output channel. The unit sustains one byte per clock
// while the record stream is not stalled: a byte lands in an input register, and
// once the result register can take a record the escape decode, the type table
// compare and a byte-wide unrolled CRC-8 update all finish in one combinational
// pass into the result register, from which the record is presented.
// Input stall rises only while the input register holds a byte and the result
// register is full and stalled.
// Escape, begin, end and error codes, the CRC polynomial and the descriptor
// and timestamp ids are set through the APB port (register i at byte
// address 4*i); write them only while no byte is in flight.
`include "assert_macros.svh"

module escaped_frame_receiver_crc8_unit import efr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // received byte stream
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,

    // record stream
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_is_error,
    output logic [3:0]         o_frame_id,
    output logic [7:0]         o_payload_first,
    output logic [7:0]         o_payload_second,
    output logic [7:0]         o_payload_third,
    output logic               o_is_timestamp,
    output logic [2:0]         o_error_kind,
    output logic [7:0]         o_bad_type_byte,

    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // one unrolled byte of the bitwise crc, 9-bit working register
    function automatic logic [7:0] crc_step(input logic [7:0] crc,
                                            input logic [7:0] din,
                                            input logic [8:0] poly);
        logic [8:0] r;
        r = {1'b0, crc};
        for (int i = 0; i < 8; i++) begin
            r = {r[7:0], din[7-i]};
            if (r[8]) begin
                r = r ^ poly;
            end
        end
        return r[7:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0] r_escape, r_begin, r_end, r_errc, r_desc_id, r_ts_id;
    logic [8:0] r_poly;
    logic       cfg_wr;
    t_reg_idx   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape  <= RST_ESCAPE;
            r_begin   <= RST_BEGIN;
            r_end     <= RST_END;
            r_errc    <= RST_ERROR;
            r_poly    <= RST_POLY;
            r_desc_id <= RST_DESCRIPTOR;
            r_ts_id   <= RST_TIMESTAMP;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ESCAPE:     r_escape  <= pwdata[7:0];
                REG_BEGIN:      r_begin   <= pwdata[7:0];
                REG_END:        r_end     <= pwdata[7:0];
                REG_ERROR:      r_errc    <= pwdata[7:0];
                REG_POLY:       r_poly    <= pwdata[8:0];
                REG_DESCRIPTOR: r_desc_id <= pwdata[7:0];
                REG_TIMESTAMP:  r_ts_id   <= pwdata[7:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ESCAPE:     prdata = {24'd0, r_escape};
            REG_BEGIN:      prdata = {24'd0, r_begin};
            REG_END:        prdata = {24'd0, r_end};
            REG_ERROR:      prdata = {24'd0, r_errc};
            REG_POLY:       prdata = {23'd0, r_poly};
            REG_DESCRIPTOR: prdata = {24'd0, r_desc_id};
            REG_TIMESTAMP:  prdata = {24'd0, r_ts_id};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input register and flow control
    // ------------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       advance;      // byte in the input register is processed
    logic       in_xfer;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_xfer = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // receiver state
    // ------------------------------------------------------------------
    logic             r_esc, n_esc;
    t_phase           r_phase, n_phase;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [ID_W-1:0]  r_id, n_id;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_pay [PAYLOAD_BYTES];

    // escape decode, command codes tested begin, end, error, literal
    logic       b_is_esc, esc_start;
    logic       cmd_begin, cmd_end, cmd_err, cmd_lit, cmd_bad;
    logic       plain;
    t_type_hit  type_hit;
    logic       in_type, in_frame, rem_zero;
    logic       pay_wr;
    logic [REM_W-1:0] pay_pos;

    assign b_is_esc  = (r_in_byte == r_escape);
    assign esc_start = !r_esc && b_is_esc;
    assign cmd_begin = r_esc && (r_in_byte == r_begin);
    assign cmd_end   = r_esc && !cmd_begin && (r_in_byte == r_end);
    assign cmd_err   = r_esc && !cmd_begin && !cmd_end && (r_in_byte == r_errc);
    assign cmd_lit   = r_esc && !cmd_begin && !cmd_end && !cmd_err && b_is_esc;
    assign cmd_bad   = r_esc && !cmd_begin && !cmd_end && !cmd_err && !b_is_esc;
    assign plain     = (!r_esc && !b_is_esc) || cmd_lit;

    assign type_hit  = type_lookup(r_in_byte);
    assign in_type   = plain && (r_phase == PH_TYPE);
    assign in_frame  = plain && (r_phase == PH_FRAME);
    assign rem_zero  = (r_rem == '0);

    // payload slot of this byte, the crc byte has no slot
    assign pay_pos = REM_W'(PAYLOAD_BYTES + 1) - r_rem;
    assign pay_wr  = advance && in_frame && (r_rem > REM_W'(1));

    // next state
    always_comb begin
        n_esc   = esc_start;
        n_phase = r_phase;
        n_rem   = r_rem;
        n_id    = r_id;
        n_crc   = r_crc;
        if (cmd_begin) begin
            n_phase = PH_TYPE;
        end else if (cmd_end || cmd_err || cmd_bad) begin
            n_phase = PH_IDLE;
        end else if (in_type) begin
            if (type_hit.hit) begin
                n_phase = PH_FRAME;
                n_id    = type_hit.id;
                n_rem   = REM_W'(PAYLOAD_BYTES + 1);
                n_crc   = r_in_byte;     // type byte seeds the crc
            end else begin
                n_phase = PH_IDLE;
            end
        end else if (in_frame) begin
            if (rem_zero) begin
                n_phase = PH_IDLE;
            end else begin
                n_rem = r_rem - REM_W'(1);
                n_crc = crc_step(r_crc, r_in_byte, r_poly);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= 1'b0;
            r_phase <= PH_IDLE;
            r_rem   <= '0;
            r_id    <= '0;
            r_crc   <= '0;
        end else if (advance) begin
            r_esc   <= n_esc;
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_id    <= n_id;
            r_crc   <= n_crc;
        end
    end

    // payload store, every slot is rewritten before a data record reads it
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            if (pay_wr && (pay_pos == REM_W'(k))) begin
                r_pay[k] <= r_in_byte;
            end
        end
    end

    // ------------------------------------------------------------------
    // record build
    // ------------------------------------------------------------------
    t_result n_out;
    logic    n_out_valid;
    logic [7:0] pay_out [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pay_out[k] = '0;
            if (k < PAYLOAD_BYTES) begin
                pay_out[k] = r_pay[k];
            end
        end
    end

    always_comb begin
        n_out       = '0;
        n_out_valid = 1'b0;
        if (cmd_begin) begin
            if (r_phase != PH_IDLE) begin
                n_out_valid      = 1'b1;
                n_out.is_error   = 1'b1;
                n_out.error_kind = ERR_BEGIN_BUSY;
            end
        end else if (cmd_end) begin
            if (r_phase != PH_FRAME || !rem_zero) begin
                n_out_valid      = 1'b1;
                n_out.is_error   = 1'b1;
                n_out.error_kind = ERR_SHORT;
            end else if (r_crc != '0) begin
                n_out_valid      = 1'b1;
                n_out.is_error   = 1'b1;
                n_out.error_kind = ERR_CRC;
            end else if (8'(r_id) != r_desc_id) begin
                // descriptor frames are dropped silently
                n_out_valid          = 1'b1;
                n_out.frame_id       = FRAME_ID_W'(r_id);
                n_out.payload_first  = pay_out[0];
                n_out.payload_second = pay_out[1];
                n_out.payload_third  = pay_out[2];
                n_out.is_timestamp   = (8'(r_id) == r_ts_id);
            end
        end else if (cmd_err) begin
            n_out_valid      = 1'b1;
            n_out.is_error   = 1'b1;
            n_out.error_kind = (r_phase == PH_IDLE) ? ERR_REMOTE : ERR_MIDFRAME;
        end else if (cmd_bad) begin
            n_out_valid      = 1'b1;
            n_out.is_error   = 1'b1;
            n_out.error_kind = ERR_BAD_ESCAPE;
        end else if (in_type && !type_hit.hit) begin
            n_out_valid         = 1'b1;
            n_out.is_error      = 1'b1;
            n_out.error_kind    = ERR_UNKNOWN_TYPE;
            n_out.bad_type_byte = r_in_byte;
        end else if (in_frame && rem_zero) begin
            n_out_valid      = 1'b1;
            n_out.is_error   = 1'b1;
            n_out.error_kind = ERR_TOO_LONG;
        end
    end

    // result register, emptied when its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_out_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_is_error       = r_out.is_error;
    assign o_frame_id       = r_out.frame_id;
    assign o_payload_first  = r_out.payload_first;
    assign o_payload_second = r_out.payload_second;
    assign o_payload_third  = r_out.payload_third;
    assign o_is_timestamp   = r_out.is_timestamp;
    assign o_error_kind     = r_out.error_kind;
    assign o_bad_type_byte  = r_out.bad_type_byte;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `ASSERT_RST(a_reset_empty, !i_rst_n |=> !r_in_valid && !r_out_valid, "pipe not empty after reset")
    `ASSERT_CLK(a_esc_once, advance && r_esc |=> !r_esc, "escape pending survived its command byte")
    `ASSERT_CLK(a_begin_type, advance && cmd_begin |=> r_phase == PH_TYPE, "begin did not open a frame")
    `ASSERT_CLK(a_rem_range, r_phase == PH_FRAME |-> r_rem <= REM_W'(PAYLOAD_BYTES + 1), "byte count out of range")
    `ASSERT_CLK(a_data_clean, r_out_valid && !r_out.is_error |-> r_out.bad_type_byte == '0, "data record carries error fields")
    `ASSERT_CLK(a_new_from_advance, r_out_valid && !$past(r_out_valid) |-> $past(advance), "record appeared without a processed byte")

endmodule

@@ sim/frame_record_checker.sv @@
`timescale 1ns / 100ps

package frame_tb_pkg;

    // shift one byte through the 9-bit crc register, msb first
    function automatic logic [7:0] crc8_shift(input logic [7:0] seed, input logic [7:0] b,
                                              input logic [8:0] poly);
        logic [8:0] r;
        r = {1'b0, seed};
        for (int i = 7; i >= 0; i--) begin
            r = {r[7:0], b[i]};
            if (r[8]) r = r ^ poly;
        end
        return r[7:0];
    endfunction

endpackage

module frame_record_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [7:0]                 i_rx_byte,

    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_is_error,
    input  logic [3:0]                 i_frame_id,
    input  logic [7:0]                 i_payload_first,
    input  logic [7:0]                 i_payload_second,
    input  logic [7:0]                 i_payload_third,
    input  logic                       i_is_timestamp,
    input  logic [2:0]                 i_error_kind,
    input  logic [7:0]                 i_bad_type_byte,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [efr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,

    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_records,
    output int                         o_error_records
);
    import efr_pkg::*;
    import frame_tb_pkg::*;

    localparam logic [7:0] TYPE_ID0  = 8'h63;
    localparam logic [7:0] TYPE_ID7  = 8'h6A;
    localparam logic [7:0] TYPE_ID8  = 8'h62;

    // register copies
    logic [7:0] cfg_escape, cfg_begin, cfg_end, cfg_error;
    logic [8:0] cfg_poly;
    logic [7:0] cfg_descriptor, cfg_timestamp;

    // receiver state
    logic       esc_pending;
    t_phase     phase;
    int         left_count;
    logic [3:0] cur_id;
    logic [7:0] payload [0:PAYLOAD_BYTES-1];
    logic [7:0] crc_state;

    t_result    expected_records [$];
    int         mismatch_count = 0;
    int         record_count   = 0;
    int         error_count    = 0;

    assign o_mismatches    = mismatch_count;
    assign o_records       = record_count;
    assign o_error_records = error_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch in record %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, record_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    function automatic t_result error_record(input t_err_kind kind, input logic [7:0] bad);
        t_result rec;
        rec = '0;
        rec.is_error      = 1'b1;
        rec.error_kind    = kind;
        rec.bad_type_byte = bad;
        return rec;
    endfunction

    function automatic t_result data_record();
        t_result rec;
        rec = '0;
        rec.frame_id       = cur_id;
        rec.payload_first  = payload[0];
        rec.payload_second = payload[1];
        rec.payload_third  = payload[2];
        rec.is_timestamp   = ({4'h0, cur_id} == cfg_timestamp);
        return rec;
    endfunction

    // advance the receiver by one byte, returns 1 when a record comes out
    function automatic bit frame_step(input logic [7:0] b, output t_result rec);
        logic [3:0] id;
        bit         known;
        int         pos;
        rec = '0;
        id  = '0;
        if (!esc_pending && b == cfg_escape) begin
            esc_pending = 1'b1;
            return 1'b0;
        end
        if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == cfg_begin) begin
                known = (phase != PH_IDLE);
                if (known) rec = error_record(ERR_BEGIN_BUSY, 8'h00);
                phase = PH_TYPE;
                return known;
            end
            if (b == cfg_end) begin
                known = 1'b1;
                if (phase != PH_FRAME || left_count != 0)
                    rec = error_record(ERR_SHORT, 8'h00);
                else if (crc_state != 8'h00)
                    rec = error_record(ERR_CRC, 8'h00);
                else if ({4'h0, cur_id} != cfg_descriptor)
                    rec = data_record();
                else
                    known = 1'b0;
                phase = PH_IDLE;
                return known;
            end
            if (b == cfg_error) begin
                rec   = error_record(phase == PH_IDLE ? ERR_REMOTE : ERR_MIDFRAME, 8'h00);
                phase = PH_IDLE;
                return 1'b1;
            end
            if (b != cfg_escape) begin
                rec   = error_record(ERR_BAD_ESCAPE, 8'h00);
                phase = PH_IDLE;
                return 1'b1;
            end
            // doubled escape falls through as a data byte
        end
        case (phase)
            PH_TYPE: begin
                known = 1'b1;
                if (b == TYPE_ID8)
                    id = 4'd8;
                else if (b >= TYPE_ID0 && b <= TYPE_ID7)
                    id = 4'(b - TYPE_ID0);
                else
                    known = 1'b0;
                if (!known) begin
                    rec   = error_record(ERR_UNKNOWN_TYPE, b);
                    phase = PH_IDLE;
                    return 1'b1;
                end
                cur_id     = id;
                left_count = PAYLOAD_BYTES + 1;
                crc_state  = b;
                phase      = PH_FRAME;
            end
            PH_FRAME: begin
                if (left_count == 0) begin
                    rec   = error_record(ERR_TOO_LONG, 8'h00);
                    phase = PH_IDLE;
                    return 1'b1;
                end
                pos = PAYLOAD_BYTES + 1 - left_count;
                if (pos < PAYLOAD_BYTES) payload[pos] = b;
                left_count--;
                crc_state = crc8_shift(crc_state, b, cfg_poly);
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result rec;
        t_result got;
        if (!i_rst_n) begin
            cfg_escape     = RST_ESCAPE;
            cfg_begin      = RST_BEGIN;
            cfg_end        = RST_END;
            cfg_error      = RST_ERROR;
            cfg_poly       = RST_POLY;
            cfg_descriptor = RST_DESCRIPTOR;
            cfg_timestamp  = RST_TIMESTAMP;
            esc_pending    = 1'b0;
            phase          = PH_IDLE;
            left_count     = 0;
            cur_id         = '0;
            crc_state      = '0;
            expected_records.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.is_error       = i_is_error;
                got.frame_id       = i_frame_id;
                got.payload_first  = i_payload_first;
                got.payload_second = i_payload_second;
                got.payload_third  = i_payload_third;
                got.is_timestamp   = i_is_timestamp;
                got.error_kind     = t_err_kind'(i_error_kind);
                got.bad_type_byte  = i_bad_type_byte;
                if (expected_records.size() == 0) begin
                    report_mismatch("record with none pending, is_error",
                                    32'(got.is_error), 0);
                end else begin
                    rec = expected_records.pop_front();
                    check_field("is_error", 32'(got.is_error), 32'(rec.is_error));
                    check_field("frame_id", 32'(got.frame_id), 32'(rec.frame_id));
                    check_field("payload_first", 32'(got.payload_first),
                                32'(rec.payload_first));
                    check_field("payload_second", 32'(got.payload_second),
                                32'(rec.payload_second));
                    check_field("payload_third", 32'(got.payload_third),
                                32'(rec.payload_third));
                    check_field("is_timestamp", 32'(got.is_timestamp),
                                32'(rec.is_timestamp));
                    check_field("error_kind", 32'(got.error_kind), 32'(rec.error_kind));
                    check_field("bad_type_byte", 32'(got.bad_type_byte),
                                32'(rec.bad_type_byte));
                end
                record_count++;
                if (got.is_error) error_count++;
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_ESCAPE:     cfg_escape     = pwdata[7:0];
                    REG_BEGIN:      cfg_begin      = pwdata[7:0];
                    REG_END:        cfg_end        = pwdata[7:0];
                    REG_ERROR:      cfg_error      = pwdata[7:0];
                    REG_POLY:       cfg_poly       = pwdata[8:0];
                    REG_DESCRIPTOR: cfg_descriptor = pwdata[7:0];
                    REG_TIMESTAMP:  cfg_timestamp  = pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (frame_step(i_rx_byte, rec)) expected_records = {expected_records, rec};
            end
        end
        o_pending <= expected_records.size();
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import efr_pkg::*;
    import frame_tb_pkg::*;

    // cycles after the last record before the unit counts as idle (a record passes the input
    // and result registers after its byte, a byte that makes no record may still be in flight)
    localparam int DRAIN_CYCLES = 6;
    // cycles with no transfer at all before the run is declared hung
    localparam int HANG_LIMIT   = 1000;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;

    // byte stream side
    logic       in_valid = 1'b0;
    logic [7:0] in_byte  = 8'h00;
    logic       byte_stall;

    // record stream side
    logic       rec_valid;
    logic       rec_stall = 1'b0;
    logic       rec_is_error;
    logic [3:0] rec_frame_id;
    logic [7:0] rec_payload_first, rec_payload_second, rec_payload_third;
    logic       rec_is_timestamp;
    logic [2:0] rec_error_kind;
    logic [7:0] rec_bad_type_byte;

    // register port
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    // results handed up by the checker
    int mismatches, pending, records, error_records;

    // stimulus knobs and the register values the frames are built against
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned stream_bytes   = 0;
    int          idle_cycles    = 0;
    logic [7:0]  cfg_escape = RST_ESCAPE;
    logic [7:0]  cfg_begin  = RST_BEGIN;
    logic [7:0]  cfg_end    = RST_END;
    logic [7:0]  cfg_error  = RST_ERROR;
    logic [8:0]  cfg_poly   = RST_POLY;

    always #4 clk = ~clk;

    escaped_frame_receiver_crc8_unit uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (byte_stall),
        .i_rx_byte        (in_byte),
        .o_valid          (rec_valid),
        .i_stall          (rec_stall),
        .o_is_error       (rec_is_error),
        .o_frame_id       (rec_frame_id),
        .o_payload_first  (rec_payload_first),
        .o_payload_second (rec_payload_second),
        .o_payload_third  (rec_payload_third),
        .o_is_timestamp   (rec_is_timestamp),
        .o_error_kind     (rec_error_kind),
        .o_bad_type_byte  (rec_bad_type_byte),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    frame_record_checker records_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (byte_stall),
        .i_rx_byte        (in_byte),
        .i_out_valid      (rec_valid),
        .i_out_stall      (rec_stall),
        .i_is_error       (rec_is_error),
        .i_frame_id       (rec_frame_id),
        .i_payload_first  (rec_payload_first),
        .i_payload_second (rec_payload_second),
        .i_payload_third  (rec_payload_third),
        .i_is_timestamp   (rec_is_timestamp),
        .i_error_kind     (rec_error_kind),
        .i_bad_type_byte  (rec_bad_type_byte),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_records        (records),
        .o_error_records  (error_records)
    );

    // record side backpressure, one fresh coin per cycle
    always @(posedge clk) begin
        rec_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // hang detector: any transfer on either channel restarts the count
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !byte_stall) || (rec_valid && !rec_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d records pending",
                     idle_cycles, pending);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one byte transfer; valid is left high so the next byte can follow back to back
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (byte_stall);
    endtask

    // data byte, doubled when it collides with the escape byte
    task automatic send_plain(input logic [7:0] b);
        if (b == cfg_escape) begin
            send_byte(cfg_escape);
            stream_bytes++;
        end
        send_byte(b);
        stream_bytes++;
    endtask

    // escape followed by a command byte
    task automatic send_code(input logic [7:0] code);
        send_byte(cfg_escape);
        send_byte(code);
        stream_bytes += 2;
    endtask

    // trailer byte that brings the crc register back to zero, if one exists
    function automatic logic [7:0] crc_seal(input logic [7:0] t, p0, p1, p2);
        logic [7:0] r;
        r = crc8_shift(t, p0, cfg_poly);
        r = crc8_shift(r, p1, cfg_poly);
        r = crc8_shift(r, p2, cfg_poly);
        for (int c = 0; c < 256; c++)
            if (crc8_shift(r, 8'(c), cfg_poly) == 8'h00) return 8'(c);
        return r;
    endfunction

    // complete frame; a nonzero flip corrupts the trailer
    task automatic send_whole_frame(input logic [7:0] t, p0, p1, p2, flip);
        logic [7:0] seal;
        seal = crc_seal(t, p0, p1, p2) ^ flip;
        send_code(cfg_begin);
        send_plain(t);
        send_plain(p0);
        send_plain(p1);
        send_plain(p2);
        send_plain(seal);
        send_code(cfg_end);
    endtask

    // stop sending and let every pending record and in-flight byte come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle and access cycle, after which the port is released
    task automatic write_reg(input t_reg_idx idx, input logic [8:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] esc_c, begin_c, end_c, error_c,
                             input logic [8:0] poly, input logic [7:0] desc, stamp);
        write_reg(REG_ESCAPE, 9'(esc_c));
        write_reg(REG_BEGIN, 9'(begin_c));
        write_reg(REG_END, 9'(end_c));
        write_reg(REG_ERROR, 9'(error_c));
        write_reg(REG_POLY, poly);
        write_reg(REG_DESCRIPTOR, 9'(desc));
        write_reg(REG_TIMESTAMP, 9'(stamp));
        cfg_escape = esc_c;
        cfg_begin  = begin_c;
        cfg_end    = end_c;
        cfg_error  = error_c;
        cfg_poly   = poly;
    endtask

    // one random frame: mostly well formed, the rest broken in one way or another
    task automatic random_frame();
        logic [7:0]  body [0:4];
        logic [7:0]  odd;
        logic [3:0]  id;
        int unsigned pick, cut;
        id      = 4'($urandom_range(8));
        body[0] = (id == 4'd8) ? 8'h62 : 8'h63 + 8'(id);
        body[1] = 8'($urandom);
        body[2] = 8'($urandom);
        body[3] = 8'($urandom);
        body[4] = crc_seal(body[0], body[1], body[2], body[3]);
        pick    = $urandom_range(99);
        if (pick < 60) begin
            send_whole_frame(body[0], body[1], body[2], body[3], 8'h00);
        end else if (pick < 68) begin
            // crc failure
            send_whole_frame(body[0], body[1], body[2], body[3], 8'($urandom_range(1, 255)));
        end else if (pick < 74) begin
            // end arrives early, possibly before the type byte
            cut = $urandom_range(4);
            send_code(cfg_begin);
            for (int k = 0; k < cut; k++) send_plain(body[k]);
            send_code(cfg_end);
        end else if (pick < 79) begin
            // one byte too many before the end
            send_code(cfg_begin);
            for (int k = 0; k < 5; k++) send_plain(body[k]);
            send_plain(8'($urandom));
            send_code(cfg_end);
        end else if (pick < 83) begin
            // type byte outside the table
            do odd = 8'($urandom); while (odd >= 8'h62 && odd <= 8'h6A);
            send_code(cfg_begin);
            send_plain(odd);
        end else if (pick < 87) begin
            // sender reports an error somewhere inside the frame
            cut = $urandom_range(5);
            send_code(cfg_begin);
            for (int k = 0; k < cut; k++) send_plain(body[k]);
            send_code(cfg_error);
        end else if (pick < 90) begin
            // partial frame cut off by a new begin
            cut = $urandom_range(1, 4);
            send_code(cfg_begin);
            for (int k = 0; k < cut; k++) send_plain(body[k]);
            send_whole_frame(body[0], body[1], body[2], body[3], 8'h00);
        end else if (pick < 93) begin
            if ($urandom_range(1)) begin
                // remote error between frames
                send_code(cfg_error);
            end else begin
                // escape followed by a byte with no meaning
                do odd = 8'($urandom);
                while (odd == cfg_escape || odd == cfg_begin || odd == cfg_end ||
                       odd == cfg_error);
                send_code(odd);
            end
        end else begin
            // line noise between frames, not counted toward the budget
            cut = $urandom_range(1, 4);
            for (int k = 0; k < cut; k++) send_byte(8'($urandom));
        end
    endtask

    task automatic random_traffic(input int unsigned quota, input bit pause_midway);
        int unsigned start;
        bit          paused;
        start  = stream_bytes;
        paused = 1'b0;
        while (stream_bytes - start < quota) begin
            random_frame();
            if (pause_midway && !paused && stream_bytes - start >= quota / 2) begin
                // hold the sender until every record is out
                drain();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles now and then, receiver stalls most cycles
        send_idle_pct  = 32;
        recv_stall_pct = 61;

        // directed part, reset register values
        send_whole_frame(8'h62, 8'h00, 8'hFF, RST_ESCAPE, 8'h00); // id 8, stuffed payload
        send_whole_frame(8'h6A, 8'h80, 8'h01, 8'h7F, 8'h00);      // highest type byte in the table
        send_whole_frame(8'h63, 8'h5A, 8'hA5, 8'h00, 8'h01);      // bad crc
        send_code(cfg_end);                                        // end while idle
        send_code(cfg_error);                                      // remote error while idle
        send_code(cfg_begin);
        send_plain(8'h6B);                                         // type just past the table
        send_code(cfg_begin);
        send_code(cfg_end);                                        // end before type byte
        send_code(cfg_begin);
        send_plain(8'h6A);
        send_plain(8'h11);
        send_code(cfg_begin);                                      // begin while busy
        send_code(cfg_error);                                      // error mid frame
        send_byte(8'hFF);                                          // plain byte while idle
        send_code(8'h55);                                          // meaningless escape
        random_traffic(220, 1'b1);
        drain();

        // upper and lower extremes of the codes, full polynomial, low frame ids
        configure(8'hFF, 8'h00, 8'h01, 8'hFE, 9'h1FF, 8'd3, 8'd5);
        send_idle_pct  = 61;
        recv_stall_pct = 32;
        random_traffic(230, 1'b0);
        drain();

        // escape at zero, polynomial with only the top bit, id 8 dropped
        configure(8'h00, 8'hFF, 8'h80, 8'h7F, 9'h100, 8'd8, 8'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(200, 1'b0);
        drain();

        // escape equal to a type byte, end and error codes colliding, polynomial
        // without the top bit
        configure(8'h63, 8'h07, 8'h09, 8'h09, 9'h0A5, 8'($urandom_range(8)),
                  8'($urandom_range(8)));
        random_traffic(90, 1'b0);
        drain();

        $display("coverage: %0d frame bytes under four register settings, all idle mixes",
                 stream_bytes);
        $display("coverage: %0d records compared, %0d of them error records",
                 records, error_records);
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
